// File: rtl/ipbc_pkg.sv
// package for the pixel to byte converter
// holds mode codes, loop lengths, the log threshold table and the
// command/status structs shared by controller and datapath
package ipbc_pkg;

  localparam int unsigned PIX_W      = 32;
  localparam int unsigned PROD_W     = 40;
  localparam int unsigned DIV_STEPS  = 40;
  localparam int unsigned SQRT_STEPS = 16;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned LOG_STEPS  = 21;
  localparam int unsigned LOG_W      = 5;
  localparam logic [7:0]  BYTE_MAX   = 8'd255;

  typedef enum logic [2:0] {
    MODE_CLAMP = 3'd0,
    MODE_LOW   = 3'd1,
    MODE_SCALE = 3'd2,
    MODE_SQRT  = 3'd4,
    MODE_LOG   = 3'd5
  } conv_mode_e;

  // ceil(e^(k-0.5)) for k = 1..21
  localparam logic [31:0] LOG_THRESH [LOG_STEPS] = '{
    32'd2, 32'd5, 32'd13, 32'd34, 32'd91, 32'd245, 32'd666, 32'd1809,
    32'd4915, 32'd13360, 32'd36316, 32'd98716, 32'd268338, 32'd729417,
    32'd1982760, 32'd5389699, 32'd14650720, 32'd39824785, 32'd108254988,
    32'd294267567, 32'd799902178
  };

  typedef struct packed {
    logic scan;
    logic load;
    logic prep;
    logic step;
    logic finish;
  } ipbc_cmd_t;

  typedef struct packed {
    logic need_iter;
    logic iter_last;
    logic out_free;
  } ipbc_stat_t;

endpackage

// File: rtl/ipbc_if.sv
// valid/ready channel interfaces of the pixel to byte converter
// depends on nothing
interface ipbc_pix_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] pixel;
  logic               first_of_frame;

  modport source (output valid, op, pixel, first_of_frame, input ready);
  modport sink   (input valid, op, pixel, first_of_frame, output ready);
endinterface

interface ipbc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       mode_error;

  modport source (output valid, byte_value, mode_error, input ready);
  modport sink   (input valid, byte_value, mode_error, output ready);
endinterface

// File: rtl/ipbc_ctrl.sv
// controller state machine of the pixel to byte converter
// depends on ipbc_pkg for the command and status structs
module ipbc_ctrl
  import ipbc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_op_i,
  output logic       in_ready_o,
  input  ipbc_stat_t stat_i,
  output ipbc_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_ITER = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i) begin
            cmd_o.load = 1'b1;
            state_d    = ST_PREP;
          end else begin
            cmd_o.scan = 1'b1;
          end
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = stat_i.need_iter ? ST_ITER : ST_FIN;
      end
      ST_ITER: begin
        cmd_o.step = 1'b1;
        if (stat_i.iter_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold the result until the output register frees up
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/ipbc_dpath.sv
// datapath of the pixel to byte converter: mode and maximum registers,
// shared bit-serial divider / square root unit, output register
// depends on ipbc_pkg
module ipbc_dpath
  import ipbc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic signed [31:0] in_pixel_i,
  input  logic               in_first_i,
  input  ipbc_cmd_t          cmd_i,
  output ipbc_stat_t         stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_err_o
);

  logic [2:0]         mode_q;
  logic signed [31:0] fmax_q, fmax_d;
  logic signed [31:0] pix_q;
  logic [31:0]        pmag_q;
  logic [31:0]        div_rem_q, div_rem_d;
  logic [39:0]        div_dq_q, div_dq_d;
  logic [31:0]        sq_rem_q, sq_rem_d;
  logic [31:0]        sq_root_q, sq_root_d;
  logic [30:0]        sq_bit_q, sq_bit_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               out_err_q, out_err_d;

  logic               fmax_big;
  logic [32:0]        div_sh;
  logic               div_ge;
  logic [31:0]        sq_sum;
  logic [7:0]         q_byte;
  logic [7:0]         sq_byte;
  logic               sq_up;
  logic [LOG_W-1:0]   log_k;
  logic [CNT_W-1:0]   cnt_last;

  assign fmax_big = fmax_q > 32'sd255;
  assign cnt_last = (mode_q == MODE_SQRT) ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(DIV_STEPS - 1);

  assign stat_o.need_iter = ((mode_q == MODE_SCALE) && fmax_big) ||
                            ((mode_q == MODE_SQRT) && !pix_q[31]);
  assign stat_o.iter_last = (cnt_q == cnt_last);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // one restoring division step, divisor is the positive frame maximum
  assign div_sh = {div_rem_q, div_dq_q[39]};
  assign div_ge = div_sh >= {1'b0, fmax_q};

  // one square root digit step
  assign sq_sum = sq_root_q + {1'b0, sq_bit_q};

  always_comb begin
    fmax_d    = fmax_q;
    div_rem_d = div_rem_q;
    div_dq_d  = div_dq_q;
    sq_rem_d  = sq_rem_q;
    sq_root_d = sq_root_q;
    sq_bit_d  = sq_bit_q;
    cnt_d     = cnt_q;
    if (cmd_i.scan && (in_first_i || (in_pixel_i > fmax_q))) begin
      fmax_d = in_pixel_i;
    end
    if (cmd_i.prep) begin
      div_rem_d = '0;
      // |p| * 255 as (|p| << 8) - |p|
      div_dq_d  = {pmag_q, 8'd0} - {8'd0, pmag_q};
      sq_rem_d  = pix_q;
      sq_root_d = '0;
      sq_bit_d  = {1'b1, 30'd0};
      cnt_d     = '0;
    end
    if (cmd_i.step) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (mode_q == MODE_SQRT) begin
        if (sq_rem_q >= sq_sum) begin
          sq_rem_d  = sq_rem_q - sq_sum;
          sq_root_d = (sq_root_q >> 1) + {1'b0, sq_bit_q};
        end else begin
          sq_root_d = sq_root_q >> 1;
        end
        sq_bit_d = sq_bit_q >> 2;
      end else begin
        div_rem_d = div_ge ? 32'(div_sh - {1'b0, fmax_q}) : div_sh[31:0];
        div_dq_d  = {div_dq_q[38:0], div_ge};
      end
    end
  end

  // low byte of the signed quotient
  assign q_byte = pix_q[31] ? 8'(~div_dq_q[7:0] + 8'd1) : div_dq_q[7:0];

  // round half up: remainder x - r*r above r
  assign sq_up   = sq_rem_q > sq_root_q;
  assign sq_byte = (sq_root_q > 32'd254) ? BYTE_MAX : 8'(sq_root_q[7:0] + {7'd0, sq_up});

  always_comb begin
    log_k = '0;
    for (int i = 0; i < LOG_STEPS; i++) begin
      if (pix_q >= $signed(LOG_THRESH[i])) begin
        log_k = LOG_W'(i + 1);
      end
    end
  end

  always_comb begin
    out_err_d = 1'b0;
    case (mode_q)
      MODE_CLAMP: begin
        if (pix_q[31]) begin
          out_byte_d = 8'd0;
        end else if (pix_q > 32'sd255) begin
          out_byte_d = BYTE_MAX;
        end else begin
          out_byte_d = pix_q[7:0];
        end
      end
      MODE_LOW: begin
        out_byte_d = pix_q[7:0];
      end
      MODE_SCALE: begin
        out_byte_d = fmax_big ? q_byte : pix_q[7:0];
      end
      MODE_SQRT: begin
        out_byte_d = pix_q[31] ? 8'd0 : sq_byte;
      end
      MODE_LOG: begin
        out_byte_d = (pix_q < 32'sd1) ? 8'd0 : {3'd0, log_k};
      end
      default: begin
        out_byte_d = 8'd0;
        out_err_d  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CLAMP;
      fmax_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      fmax_q <= fmax_d;
      cnt_q  <= cnt_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q  <= in_pixel_i;
      pmag_q <= in_pixel_i[31] ? 32'(-in_pixel_i) : in_pixel_i;
    end
    div_rem_q <= div_rem_d;
    div_dq_q  <= div_dq_d;
    sq_rem_q  <= sq_rem_d;
    sq_root_q <= sq_root_d;
    sq_bit_q  <= sq_bit_d;
    if (cmd_i.finish) begin
      out_byte_q <= out_byte_d;
      out_err_q  <= out_err_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_err_o   = out_err_q;

endmodule

// File: rtl/int_pixel_to_byte_convert_top.sv
// Pixel to byte converter, top level.
// Input channel pix_i carries op, pixel and first_of_frame; output channel
// byte_o carries byte_value and mode_error; both transfer on valid && ready.
// cfg_we_i/cfg_wdata_i write the 3-bit conversion mode (write it while idle).
// A scan transfer (op 0) updates the frame maximum register and returns
// nothing; the next item is taken in the following cycle.
// A convert transfer (op 1) returns one byte. Clamp, low byte, log,
// unsupported modes and the unscaled cases go from the prepare state
// straight to the finish state; square root runs 16 digit steps and
// scaling by the maximum runs 40 restoring division steps in the shared
// iteration unit between the two. pix_i.ready stays low until the result
// sits in the output register.
// The output register lets a new item be taken while a result waits; if
// the receiver stalls, a second result is held in the datapath and the
// controller keeps pix_i.ready low until the register is free.
// Reset clears the mode to clamp, the frame maximum to zero and the output
// valid flag.
// depends on ipbc_pkg, ipbc_if, ipbc_ctrl, ipbc_dpath
module int_pixel_to_byte_convert_top
  import ipbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  ipbc_pix_if.sink    pix_i,
  ipbc_byte_if.source byte_o
);

  ipbc_cmd_t  cmd;
  ipbc_stat_t stat;

  ipbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_op_i    (pix_i.op),
    .in_ready_o (pix_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ipbc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_pixel_i  (pix_i.pixel),
    .in_first_i  (pix_i.first_of_frame),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (byte_o.valid),
    .out_ready_i (byte_o.ready),
    .out_byte_o  (byte_o.byte_value),
    .out_err_o   (byte_o.mode_error)
  );

endmodule

// File: rtl/ipbc_checker.sv
// port-level checks of the pixel to byte converter and their bind
// depends on int_pixel_to_byte_convert_top
module ipbc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_op_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_err_i
);

  // a waiting result holds until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output dropped while stalled");

  // unsupported mode always reports a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_err_i |-> out_byte_i == 8'd0)
    else $error("mode error with nonzero byte");

  // a scan transfer never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_op_i && !out_valid_i |=> !out_valid_i)
    else $error("scan produced a result");

  // a convert transfer holds input ready low in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i |=> !in_ready_i)
    else $error("input taken while converting");

endmodule

bind int_pixel_to_byte_convert_top ipbc_checker u_ipbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .in_op_i     (pix_i.op),
  .out_valid_i (byte_o.valid),
  .out_ready_i (byte_o.ready),
  .out_byte_i  (byte_o.byte_value),
  .out_err_i   (byte_o.mode_error)
);
